// ===== rtl/ims_pkg.sv =====
// ----------------------------------------------------------------------------
// ims_pkg
// shared types, codes and helpers of the i2c master bit sequencer
// ----------------------------------------------------------------------------
package ims_pkg;

   // width of the phase hold counter
   localparam int TIMER_BITS = 8;

   // command codes
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_START    = 3'd1;
   localparam logic [2:0] OP_STOP     = 3'd2;
   localparam logic [2:0] OP_WRITE    = 3'd3;
   localparam logic [2:0] OP_READ     = 3'd4;
   localparam logic [2:0] OP_SEND_ACK = 3'd5;
   localparam logic [2:0] OP_RECV_ACK = 3'd6;

   // register indexes
   localparam logic CSR_SETUP_TICKS = 1'b0;
   localparam logic CSR_HIGH_TICKS  = 1'b1;

   // reset values of the timing registers
   localparam logic [7:0] SETUP_TICKS_RST = 8'd2;
   localparam logic [7:0] HIGH_TICKS_RST  = 8'd5;

   // bits in one byte, compared against the bit counter
   localparam logic [3:0] BYTE_BITS = 4'd8;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_S0   = 5'd1,
      PH_S1   = 5'd2,
      PH_S2   = 5'd3,
      PH_P0   = 5'd4,
      PH_P1   = 5'd5,
      PH_P2   = 5'd6,
      PH_P3   = 5'd7,
      PH_W0   = 5'd8,
      PH_W1   = 5'd9,
      PH_W2   = 5'd10,
      PH_W3   = 5'd11,
      PH_W4   = 5'd12,
      PH_W5   = 5'd13,
      PH_R0   = 5'd14,
      PH_R1   = 5'd15,
      PH_A0   = 5'd16,
      PH_A1   = 5'd17,
      PH_A2   = 5'd18,
      PH_A3   = 5'd19
   } phase_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] wr_data;
      logic       ack_drive;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic       nack;
   } rsp_type;

   typedef struct packed {
      logic [7:0] setup_ticks;
      logic [7:0] high_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type             phase;
      logic [3:0]            bit_index;
      logic [7:0]            shift_byte;
      logic [TIMER_BITS-1:0] delay_count;
      logic                  ack_choice;
      logic                  scl_level;
      logic                  sda_level;
      logic                  nack_flag;
      logic [7:0]            rx_byte;
   } seq_state_type;

   // hold length from a timing register, zero counts as one tick
   function automatic logic [TIMER_BITS-1:0] hold_ticks(input logic [7:0] ticks);
      logic [TIMER_BITS-1:0] v;
      v = TIMER_BITS'(ticks);
      return (v == '0) ? TIMER_BITS'(1) : v;
   endfunction

endpackage

// ===== rtl/ims_step.sv =====
// ----------------------------------------------------------------------------
// ims_step
// next sequencer state and line levels for one timebase tick
// ----------------------------------------------------------------------------
module ims_step (
   input  ims_pkg::seq_state_type state,
   input  ims_pkg::cfg_type       cfg,
   input  ims_pkg::req_type       item,
   output ims_pkg::seq_state_type state_nx,
   output ims_pkg::rsp_type       rsp
);

   ims_pkg::seq_state_type nx;
   ims_pkg::phase_type     tgt;
   logic                   enter_en;
   logic                   done;

   always_comb begin
      nx       = state;
      tgt      = ims_pkg::PH_IDLE;
      enter_en = 1'b0;
      done     = 1'b0;

      if (state.phase == ims_pkg::PH_IDLE) begin
         case (item.opcode)
            ims_pkg::OP_START: begin
               enter_en = 1'b1;
               tgt      = ims_pkg::PH_S0;
            end
            ims_pkg::OP_STOP: begin
               enter_en = 1'b1;
               tgt      = ims_pkg::PH_P0;
            end
            ims_pkg::OP_WRITE: begin
               nx.shift_byte = item.wr_data;
               nx.bit_index  = '0;
               enter_en      = 1'b1;
               tgt           = ims_pkg::PH_W0;
            end
            ims_pkg::OP_READ: begin
               nx.shift_byte = '0;
               nx.bit_index  = '0;
               nx.ack_choice = item.ack_drive;
               enter_en      = 1'b1;
               tgt           = ims_pkg::PH_R0;
            end
            ims_pkg::OP_SEND_ACK: begin
               nx.ack_choice = item.ack_drive;
               enter_en      = 1'b1;
               tgt           = ims_pkg::PH_A0;
            end
            ims_pkg::OP_RECV_ACK: begin
               enter_en = 1'b1;
               tgt      = ims_pkg::PH_W3;
            end
            default: ;
         endcase
      end else if (state.delay_count > ims_pkg::TIMER_BITS'(1)) begin
         nx.delay_count = state.delay_count - ims_pkg::TIMER_BITS'(1);
      end else begin
         enter_en = 1'b1;
         unique case (state.phase)
            ims_pkg::PH_S0: tgt = ims_pkg::PH_S1;
            ims_pkg::PH_S1: tgt = ims_pkg::PH_S2;
            ims_pkg::PH_P0: tgt = ims_pkg::PH_P1;
            ims_pkg::PH_P1: tgt = ims_pkg::PH_P2;
            ims_pkg::PH_P2: tgt = ims_pkg::PH_P3;
            ims_pkg::PH_W0: tgt = ims_pkg::PH_W1;
            ims_pkg::PH_W1: tgt = ims_pkg::PH_W2;
            ims_pkg::PH_W2: begin
               // next data bit, or on to the ack slot
               nx.shift_byte = {state.shift_byte[6:0], 1'b0};
               nx.bit_index  = state.bit_index + 4'd1;
               tgt = (nx.bit_index < ims_pkg::BYTE_BITS) ? ims_pkg::PH_W0 : ims_pkg::PH_W3;
            end
            ims_pkg::PH_W3: tgt = ims_pkg::PH_W4;
            ims_pkg::PH_W4: tgt = ims_pkg::PH_W5;
            ims_pkg::PH_R0: tgt = ims_pkg::PH_R1;
            ims_pkg::PH_R1: begin
               tgt = (state.bit_index < ims_pkg::BYTE_BITS) ? ims_pkg::PH_R0 : ims_pkg::PH_A0;
            end
            ims_pkg::PH_A0: tgt = ims_pkg::PH_A1;
            ims_pkg::PH_A1: tgt = ims_pkg::PH_A2;
            ims_pkg::PH_A2: tgt = ims_pkg::PH_A3;
            default:        tgt = ims_pkg::PH_A3;
         endcase
      end

      if (enter_en) begin
         nx.phase = tgt;
         unique case (tgt) inside
            ims_pkg::PH_S0: begin
               nx.sda_level   = 1'b1;
               nx.scl_level   = 1'b1;
               nx.delay_count = ims_pkg::hold_ticks(cfg.high_ticks);
            end
            ims_pkg::PH_S1: begin
               nx.sda_level   = 1'b0;
               nx.delay_count = ims_pkg::hold_ticks(cfg.high_ticks);
            end
            ims_pkg::PH_S2: begin
               nx.scl_level = 1'b0;
               nx.phase     = ims_pkg::PH_IDLE;
               done         = 1'b1;
            end
            ims_pkg::PH_P0: begin
               nx.scl_level   = 1'b0;
               nx.sda_level   = 1'b0;
               nx.delay_count = ims_pkg::hold_ticks(cfg.high_ticks);
            end
            ims_pkg::PH_P1: begin
               nx.scl_level   = 1'b1;
               nx.delay_count = ims_pkg::hold_ticks(cfg.high_ticks);
            end
            ims_pkg::PH_P2: begin
               nx.sda_level   = 1'b1;
               nx.delay_count = ims_pkg::hold_ticks(cfg.high_ticks);
            end
            ims_pkg::PH_P3: begin
               nx.phase = ims_pkg::PH_IDLE;
               done     = 1'b1;
            end
            ims_pkg::PH_W0: begin
               nx.sda_level   = nx.shift_byte[7];
               nx.delay_count = ims_pkg::hold_ticks(cfg.setup_ticks);
            end
            ims_pkg::PH_W1, ims_pkg::PH_W4, ims_pkg::PH_A1: begin
               nx.scl_level   = 1'b1;
               nx.delay_count = ims_pkg::hold_ticks(cfg.high_ticks);
            end
            ims_pkg::PH_W2, ims_pkg::PH_A2: begin
               nx.scl_level   = 1'b0;
               nx.delay_count = ims_pkg::hold_ticks(cfg.setup_ticks);
            end
            ims_pkg::PH_W3: begin
               nx.sda_level   = 1'b1;
               nx.delay_count = ims_pkg::hold_ticks(cfg.setup_ticks);
            end
            ims_pkg::PH_W5: begin
               nx.nack_flag = item.sda_in;
               nx.scl_level = 1'b0;
               nx.phase     = ims_pkg::PH_IDLE;
               done         = 1'b1;
            end
            ims_pkg::PH_R0: begin
               nx.sda_level   = 1'b1;
               nx.scl_level   = 1'b1;
               nx.delay_count = ims_pkg::hold_ticks(cfg.high_ticks);
            end
            ims_pkg::PH_R1: begin
               // sample at the end of scl high
               nx.shift_byte = {nx.shift_byte[6:0], item.sda_in};
               nx.scl_level  = 1'b0;
               nx.bit_index  = nx.bit_index + 4'd1;
               if (nx.bit_index >= ims_pkg::BYTE_BITS) begin
                  nx.rx_byte = nx.shift_byte;
               end
               nx.delay_count = ims_pkg::hold_ticks(cfg.high_ticks);
            end
            ims_pkg::PH_A0: begin
               nx.sda_level   = ~nx.ack_choice;
               nx.delay_count = ims_pkg::hold_ticks(cfg.setup_ticks);
            end
            default: begin
               nx.sda_level = 1'b1;
               nx.phase     = ims_pkg::PH_IDLE;
               done         = 1'b1;
            end
         endcase
      end
   end

   assign state_nx     = nx;
   assign rsp.scl_out  = nx.scl_level;
   assign rsp.sda_out  = nx.sda_level;
   assign rsp.busy_res = (nx.phase != ims_pkg::PH_IDLE);
   assign rsp.done_res = done;
   assign rsp.rx_data  = nx.rx_byte;
   assign rsp.nack     = nx.nack_flag;

endmodule

// ===== rtl/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// i2c master line sequencer driven by one timebase tick per request
// ----------------------------------------------------------------------------
// usage
//   req channel: one transfer per timebase tick, carrying an optional command
//   (start, stop, write, read, send ack, receive ack), the write byte, the ack
//   choice and the sampled sda level. a command is ignored while busy.
//   rsp channel: exactly one transfer per request, giving scl/sda drive levels
//   after that tick, busy, a done pulse, the last read byte and the nack flag.
//   csr channel: writes setup_ticks (index 0) and high_ticks (index 1); always
//   ready, and only to be written while the sequencer is idle.
// timing
//   a request lands in an input register; the sequencer step runs between that
//   register and the response register, so a response is registered once the
//   tick moves on from the input register. throughput is one tick per cycle
//   while rsp_stall is low, set by the combinational step between registers.
// reset and stall
//   synchronous reset empties both registers, idles the sequencer, releases
//   scl and sda and loads the timing registers with 2 and 5 ticks.
//   while rsp_stall holds a response, one more request is still taken into the
//   input register; only then does req_stall rise.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
   input  logic             clock,
   input  logic             reset,

   // tick requests
   input  logic             req_valid,
   output logic             req_stall,
   input  ims_pkg::req_type req_data,

   // per tick responses
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ims_pkg::rsp_type rsp_data,

   // timing registers
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

   // input register
   logic             in_valid_ff;
   logic             in_valid_in;
   ims_pkg::req_type in_data_ff;

   // response register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   ims_pkg::rsp_type rsp_data_ff;

   // sequencer state and timing registers
   ims_pkg::seq_state_type state_ff;
   ims_pkg::seq_state_type state_in;
   ims_pkg::cfg_type       cfg_ff;
   ims_pkg::cfg_type       cfg_in;

   ims_pkg::rsp_type step_rsp;
   logic             advance;
   logic             req_take;

   // the held tick moves on when the response register is free or emptying
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   ims_step u_step (
      .state    (state_ff),
      .cfg      (cfg_ff),
      .item     (in_data_ff),
      .state_nx (state_in),
      .rsp      (step_rsp)
   );

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ims_pkg::CSR_SETUP_TICKS: cfg_in.setup_ticks = csr_wdata;
            ims_pkg::CSR_HIGH_TICKS:  cfg_in.high_ticks  = csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{setup_ticks: ims_pkg::SETUP_TICKS_RST,
                           high_ticks:  ims_pkg::HIGH_TICKS_RST};
         state_ff     <= '{phase:       ims_pkg::PH_IDLE,
                           bit_index:   '0,
                           shift_byte:  '0,
                           delay_count: '0,
                           ack_choice:  1'b0,
                           scl_level:   1'b1,
                           sda_level:   1'b1,
                           nack_flag:   1'b0,
                           rx_byte:     '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         // the sequencer moves exactly once per tick handed on
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a running phase always has a live hold count
   a_busy_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != ims_pkg::PH_IDLE) |-> (state_ff.delay_count != '0))
      else $error("sequencer busy with zero hold count");

   // a completing tick never reports busy
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_res) |-> !rsp_data_ff.busy_res)
      else $error("done reported while still busy");

   // a tick held back in the input register is kept intact
   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("held tick lost or changed");
`endif

endmodule
